[hw/rtl/ism_pkg.sv]
package ism_pkg;

  // Sizing of the sample path and the tallies.
  localparam int COUNT_BITS = 24;
  localparam int FRAC_BITS = 16;
  localparam int TALLY_W = COUNT_BITS + 1;
  localparam int FIX_W = FRAC_BITS + 4;
  localparam int DIFF_W = FIX_W + 1;
  localparam int ACC_W = 64;
  localparam int SUM_ABS_W = 48;
  localparam int MSE_W = 38;
  localparam int PSNR_W = 16;
  localparam int COS_W = 32;
  localparam int Q16_W = 20;
  localparam int CNT_OUT_W = 25;
  localparam int LOG_W = 22;
  localparam int STEP_W = 7;

  localparam logic [TALLY_W-1:0] PAIR_LIMIT = TALLY_W'(1) << COUNT_BITS;
  localparam logic [FIX_W-1:0] SAT_MAG = FIX_W'(1) << (FRAC_BITS + 2);

  // Output scaling of the mean squared error to Q6.32.
  localparam int MSE_SH = 32 - 2 * FRAC_BITS;
  localparam int MSE_LSH = (MSE_SH > 0) ? MSE_SH : 0;
  localparam int MSE_RSH = (MSE_SH < 0) ? -MSE_SH : 0;
  localparam logic [63:0] MSE_MAX = (64'd1 << MSE_W) - 64'd1;

  // Output scaling of differences to Q4.16.
  localparam int Q16_SH = 16 - FRAC_BITS;
  localparam int Q16_LSH = (Q16_SH > 0) ? Q16_SH : 0;
  localparam int Q16_RSH = (Q16_SH < 0) ? -Q16_SH : 0;
  localparam logic [63:0] DIFF16_MAX = 64'd524288;

  // PSNR arithmetic constants.
  localparam int LOG_OFFSET = 2 * FRAC_BITS * 65536;
  localparam int LOG10_2_Q16 = 197283;
  localparam int PSNR_MIN = -5120;
  localparam int PSNR_MAX = 32767;
  localparam int COS_ONE = 1073741824;

  // Configuration register indexes.
  localparam logic [1:0] REG_COS_TH = 2'd0;
  localparam logic [1:0] REG_PSNR_TH = 2'd1;
  localparam logic [1:0] REG_PSNR_CAP = 2'd2;

  localparam logic [30:0] COS_TH_RESET = 31'd1072668082;
  localparam logic [14:0] PSNR_TH_RESET = 15'd7680;
  localparam logic [14:0] PSNR_CAP_RESET = 15'd25344;

  typedef struct packed {
    logic bad;
    logic signed [FIX_W-1:0] val;
  } fixed_t;

  typedef struct packed {
    logic [ACC_W-1:0] sum_sq;
    logic [SUM_ABS_W-1:0] sum_abs;
    logic [FIX_W-1:0] peak;
    logic [ACC_W-1:0] dot;
    logic [ACC_W-1:0] norm_a;
    logic [ACC_W-1:0] norm_b;
    logic [TALLY_W-1:0] bad_a;
    logic [TALLY_W-1:0] bad_b;
    logic [TALLY_W-1:0] pairs;
  } acc_t;

  typedef enum logic {OP_DIV, OP_SQRT} iter_op_t;

  typedef struct packed {
    iter_op_t op;
    logic [63:0] rem_init;
    logic [63:0] num;
    logic [63:0] den;
    logic [STEP_W-1:0] steps;
  } iter_cmd_t;

  // Float pattern to signed fixed point, round half away, saturate at 4.0.
  function automatic fixed_t to_fixed(input logic [31:0] bits);
    fixed_t r;
    logic [7:0] ex;
    logic [63:0] sig;
    logic [63:0] mag;
    logic signed [9:0] sh;
    logic [8:0] nsh;
    logic [FIX_W-1:0] mag_f;
    ex = bits[30:23];
    sig = {40'd0, (ex != 8'd0), bits[22:0]};
    sh = $signed({2'b00, ((ex != 8'd0) ? ex : 8'd1)}) - 10'sd150 + $signed(10'(FRAC_BITS));
    nsh = 9'(-sh);
    if (sh >= 10'sd0) begin
      mag = (sh >= 10'sd40) ? 64'(SAT_MAG) : (sig << sh[5:0]);
    end else begin
      mag = (nsh > 9'd25) ? 64'd0 : ((sig + (64'd1 << (nsh - 9'd1))) >> nsh);
    end
    if (mag > 64'(SAT_MAG)) begin
      mag = 64'(SAT_MAG);
    end
    mag_f = mag[FIX_W-1:0];
    r.bad = (ex == 8'hFF);
    if (r.bad) begin
      r.val = '0;
    end else if (bits[31]) begin
      r.val = -$signed(mag_f);
    end else begin
      r.val = $signed(mag_f);
    end
    return r;
  endfunction

  function automatic logic [MSE_W-1:0] scale_mse(input logic [63:0] q);
    logic [63:0] r;
    if (MSE_LSH > 0) begin
      r = (q > (MSE_MAX >> MSE_LSH)) ? MSE_MAX : (q << MSE_LSH);
    end else begin
      r = q >> MSE_RSH;
    end
    if (r > MSE_MAX) begin
      r = MSE_MAX;
    end
    return r[MSE_W-1:0];
  endfunction

  function automatic logic [Q16_W-1:0] to_q16(input logic [63:0] x);
    logic [63:0] r;
    if (Q16_LSH > 0) begin
      r = (x > (DIFF16_MAX >> Q16_LSH)) ? DIFF16_MAX : (x << Q16_LSH);
    end else begin
      r = x >> Q16_RSH;
    end
    if (r > DIFF16_MAX) begin
      r = DIFF16_MAX;
    end
    return r[Q16_W-1:0];
  endfunction

  function automatic iter_cmd_t mk_div(input logic [63:0] rem_init, input logic [63:0] num,
                                       input logic [63:0] den, input logic [STEP_W-1:0] steps);
    iter_cmd_t c;
    c.op = OP_DIV;
    c.rem_init = rem_init;
    c.num = num;
    c.den = den;
    c.steps = steps;
    return c;
  endfunction

  function automatic iter_cmd_t mk_sqrt(input logic [63:0] x);
    iter_cmd_t c;
    c.op = OP_SQRT;
    c.rem_init = x;
    c.num = 64'd1 << 62;
    c.den = '0;
    c.steps = STEP_W'(32);
    return c;
  endfunction

endpackage

[hw/rtl/ism_stream_if.sv]
// Sample pair word channel.
interface ism_in_if;
  logic valid;
  logic ready;
  logic [31:0] sample_a_bits;
  logic [31:0] sample_b_bits;
  logic last_sample;
  modport source(output valid, sample_a_bits, sample_b_bits, last_sample, input ready);
  modport sink(input valid, sample_a_bits, sample_b_bits, last_sample, output ready);
endinterface

// Metrics result word channel.
interface ism_out_if;
  logic valid;
  logic ready;
  logic [ism_pkg::MSE_W-1:0] mean_sq_error;
  logic signed [ism_pkg::PSNR_W-1:0] psnr_db;
  logic signed [ism_pkg::COS_W-1:0] cosine;
  logic [ism_pkg::Q16_W-1:0] max_abs_diff;
  logic [ism_pkg::Q16_W-1:0] mean_abs_diff;
  logic [ism_pkg::CNT_OUT_W-1:0] bad_count_a;
  logic [ism_pkg::CNT_OUT_W-1:0] bad_count_b;
  logic [ism_pkg::CNT_OUT_W-1:0] sample_total;
  logic pass_flag;
  modport source(output valid, mean_sq_error, psnr_db, cosine, max_abs_diff, mean_abs_diff,
                 bad_count_a, bad_count_b, sample_total, pass_flag, input ready);
  modport sink(input valid, mean_sq_error, psnr_db, cosine, max_abs_diff, mean_abs_diff,
               bad_count_a, bad_count_b, sample_total, pass_flag, output ready);
endinterface

[hw/rtl/ism_mac.sv]
module ism_mac (
  input  logic           clk,
  input  logic           rst,
  input  logic           start,
  input  ism_pkg::fixed_t fix_a,
  input  ism_pkg::fixed_t fix_b,
  input  logic           clear,
  output ism_pkg::acc_t  acc,
  output logic           busy
);

  logic [1:0] phase;
  logic signed [ism_pkg::DIFF_W-1:0] va, vb, dd;
  logic signed [ism_pkg::DIFF_W-1:0] op_x, op_y;
  logic signed [2*ism_pkg::DIFF_W-1:0] prod;
  logic [63:0] prod64;
  logic signed [ism_pkg::DIFF_W-1:0] diff_now;
  logic [ism_pkg::FIX_W-1:0] abs_now;
  logic take, good;

  // A pair counts only while the tally has room.
  assign take = start && (acc.pairs < ism_pkg::PAIR_LIMIT);
  assign good = !fix_a.bad && !fix_b.bad;
  assign diff_now = ism_pkg::DIFF_W'(fix_a.val) - ism_pkg::DIFF_W'(fix_b.val);
  assign abs_now = ism_pkg::FIX_W'(diff_now[ism_pkg::DIFF_W-1] ? -diff_now : diff_now);

  // The one multiplier walks through the four products of a pair.
  always_comb begin
    case (phase)
      2'd0: begin op_x = dd; op_y = dd; end
      2'd1: begin op_x = va; op_y = vb; end
      2'd2: begin op_x = va; op_y = va; end
      default: begin op_x = vb; op_y = vb; end
    endcase
    prod = op_x * op_y;
    prod64 = 64'(prod);
  end

  // Tallies and accumulators.
  always_ff @(posedge clk) begin
    if (rst || clear) begin
      acc <= '0;
      busy <= 1'b0;
      phase <= 2'd0;
    end else if (take) begin
      acc.pairs <= acc.pairs + 1'b1;
      if (fix_a.bad) begin
        acc.bad_a <= acc.bad_a + 1'b1;
      end
      if (fix_b.bad) begin
        acc.bad_b <= acc.bad_b + 1'b1;
      end
      if (good) begin
        va <= ism_pkg::DIFF_W'(fix_a.val);
        vb <= ism_pkg::DIFF_W'(fix_b.val);
        dd <= diff_now;
        acc.sum_abs <= acc.sum_abs + ism_pkg::SUM_ABS_W'(abs_now);
        if (abs_now > acc.peak) begin
          acc.peak <= abs_now;
        end
        busy <= 1'b1;
        phase <= 2'd0;
      end
    end else if (busy) begin
      case (phase)
        2'd0: acc.sum_sq <= acc.sum_sq + prod64;
        2'd1: acc.dot <= acc.dot + prod64;
        2'd2: acc.norm_a <= acc.norm_a + prod64;
        default: acc.norm_b <= acc.norm_b + prod64;
      endcase
      phase <= phase + 2'd1;
      if (phase == 2'd3) begin
        busy <= 1'b0;
      end
    end
  end

endmodule

[hw/rtl/ism_iter.sv]
module ism_iter (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  ism_pkg::iter_cmd_t cmd,
  output logic               done,
  output logic [63:0]        result
);

  logic active;
  ism_pkg::iter_op_t op;
  logic [63:0] rem, num, den, q;
  logic [ism_pkg::STEP_W-1:0] left;
  logic [65:0] op_a, op_b, diff;
  logic ge;

  // Shared compare and subtract: a division step or a square root step.
  always_comb begin
    if (op == ism_pkg::OP_SQRT) begin
      op_a = {2'b00, rem};
      op_b = {1'b0, ({1'b0, q} + {1'b0, num})};
    end else begin
      op_a = {1'b0, rem, num[63]};
      op_b = {2'b00, den};
    end
    diff = op_a - op_b;
    ge = !diff[65];
  end

  assign result = q;

  // Step sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        op <= cmd.op;
        rem <= cmd.rem_init;
        num <= cmd.num;
        den <= cmd.den;
        q <= '0;
        left <= cmd.steps;
      end else if (active) begin
        if (op == ism_pkg::OP_SQRT) begin
          if (ge) begin
            rem <= diff[63:0];
          end
          q <= ge ? ((q >> 1) + num) : (q >> 1);
          num <= num >> 2;
        end else begin
          rem <= ge ? diff[63:0] : {rem[62:0], num[63]};
          q <= {q[62:0], ge};
          num <= num << 1;
        end
        left <= left - 1'b1;
        if (left == ism_pkg::STEP_W'(1)) begin
          active <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

[hw/rtl/ism_log2.sv]
module ism_log2 (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       start,
  input  logic [63:0]                x,
  output logic                       done,
  output logic [ism_pkg::LOG_W-1:0]  result
);

  typedef enum logic [1:0] {L_IDLE, L_NORM, L_SQ} lstate_t;

  lstate_t state;
  logic [63:0] y;
  logic [31:0] m;
  logic [5:0] k;
  logic [15:0] frac;
  logic [3:0] bit_idx;
  logic [63:0] sq;
  logic [32:0] sq_sh;

  // Squaring of the Q1.31 mantissa, truncated.
  always_comb begin
    sq = m * m;
    sq_sh = sq[63:31];
  end

  assign result = {k, frac};

  // Normalize one bit a cycle, then one fraction bit a cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= L_IDLE;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        L_IDLE: begin
          if (start) begin
            y <= x;
            k <= 6'd63;
            state <= L_NORM;
          end
        end
        L_NORM: begin
          if (!y[63] && (k != 6'd0)) begin
            y <= y << 1;
            k <= k - 6'd1;
          end else begin
            m <= y[63:32];
            frac <= '0;
            bit_idx <= 4'd15;
            state <= L_SQ;
          end
        end
        L_SQ: begin
          if (sq_sh[32]) begin
            frac[bit_idx] <= 1'b1;
            m <= sq_sh[32:1];
          end else begin
            m <= sq_sh[31:0];
          end
          bit_idx <= bit_idx - 4'd1;
          if (bit_idx == 4'd0) begin
            state <= L_IDLE;
            done <= 1'b1;
          end
        end
        default: state <= L_IDLE;
      endcase
    end
  end

endmodule

[hw/rtl/image_similarity_metrics.sv]
// Per sample pair: the four products pass in turn through the shared multiplier before the
// next pair is accepted; a pair with a NaN or Inf sample, or one past the full tally, skips
// the multiplier. After the last pair, the bit-serial divide/square-root unit (up to
// 64 + 48 + 32 + 32 + 30 steps) and the log2 unit (up to 63 + 16 steps, run twice) work out
// the metrics; the result word then waits in an output register while the next image streams.
// Reset clears all accumulators and tallies and restores the threshold and cap registers.
module image_similarity_metrics (
  input  logic        clk,
  input  logic        rst,
  ism_in_if.sink      samples,
  ism_out_if.source   results,
  input  logic        cfg_wen,
  input  logic [1:0]  cfg_addr,
  input  logic [30:0] cfg_wdata
);

  typedef enum logic [3:0] {
    S_IDLE, S_MAC, S_DIV_SQ, S_DIV_ABS, S_SQRT_A, S_SQRT_B, S_DEN, S_COS_CHK, S_COS,
    S_LOG_GO, S_LOG_S, S_LOG_N, S_PSNR, S_PASS, S_OUT
  } state_t;

  state_t state;
  logic accept, last_r;
  ism_pkg::fixed_t fix_a, fix_b;
  ism_pkg::acc_t acc;
  logic mac_busy, mac_clear;
  logic iter_start, iter_done;
  ism_pkg::iter_cmd_t iter_cmd;
  logic [63:0] iter_result;
  logic log_start, log_done;
  logic [63:0] log_x;
  logic [ism_pkg::LOG_W-1:0] log_result, log_s;
  logic [30:0] cos_th;
  logic [14:0] psnr_th, psnr_cap;
  logic [ism_pkg::MSE_W-1:0] mse_r;
  logic [ism_pkg::Q16_W-1:0] mean_r;
  logic signed [ism_pkg::PSNR_W-1:0] psnr_r;
  logic signed [ism_pkg::COS_W-1:0] cos_r;
  logic [31:0] root_a, root_b;
  logic [63:0] den_r, cmag;
  logic cneg, pass_r;
  logic signed [24:0] log_d;
  logic signed [44:0] pnum;
  logic signed [20:0] psnr_full;
  logic signed [ism_pkg::PSNR_W-1:0] psnr_clamped;
  logic out_valid, out_load;
  logic [ism_pkg::MSE_W-1:0] mse_o;
  logic signed [ism_pkg::PSNR_W-1:0] psnr_o;
  logic signed [ism_pkg::COS_W-1:0] cos_o;
  logic [ism_pkg::Q16_W-1:0] max_o, mean_o;
  logic [ism_pkg::CNT_OUT_W-1:0] bad_a_o, bad_b_o, total_o;
  logic pass_o;

  // Input word conversion and handshake.
  assign fix_a = ism_pkg::to_fixed(samples.sample_a_bits);
  assign fix_b = ism_pkg::to_fixed(samples.sample_b_bits);
  assign samples.ready = (state == S_IDLE);
  assign accept = samples.valid && samples.ready;

  // The finished image moves to the output register once that register is free.
  assign out_load = (state == S_OUT) && (!out_valid || results.ready);
  assign mac_clear = out_load;

  ism_mac u_mac (
    .clk(clk), .rst(rst), .start(accept), .fix_a(fix_a), .fix_b(fix_b),
    .clear(mac_clear), .acc(acc), .busy(mac_busy)
  );

  ism_iter u_iter (
    .clk(clk), .rst(rst), .start(iter_start), .cmd(iter_cmd),
    .done(iter_done), .result(iter_result)
  );

  ism_log2 u_log2 (
    .clk(clk), .rst(rst), .start(log_start), .x(log_x),
    .done(log_done), .result(log_result)
  );

  // PSNR from the two logs: ten log10 of one over the MSE, rounded to nearest.
  always_comb begin
    log_d = $signed({3'b000, log_s}) - $signed({3'b000, log_result})
            - $signed(25'(ism_pkg::LOG_OFFSET));
    pnum = -(45'(log_d)) * $signed(45'(ism_pkg::LOG10_2_Q16)) + 45'sd8388608;
    psnr_full = 21'(pnum >>> 24);
    if (psnr_full < $signed(21'(ism_pkg::PSNR_MIN))) begin
      psnr_clamped = 16'(ism_pkg::PSNR_MIN);
    end else if (psnr_full > $signed(21'(ism_pkg::PSNR_MAX))) begin
      psnr_clamped = 16'(ism_pkg::PSNR_MAX);
    end else begin
      psnr_clamped = 16'(psnr_full);
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      cos_th <= ism_pkg::COS_TH_RESET;
      psnr_th <= ism_pkg::PSNR_TH_RESET;
      psnr_cap <= ism_pkg::PSNR_CAP_RESET;
    end else if (cfg_wen) begin
      unique case (cfg_addr)
        ism_pkg::REG_COS_TH: cos_th <= cfg_wdata;
        ism_pkg::REG_PSNR_TH: psnr_th <= cfg_wdata[14:0];
        ism_pkg::REG_PSNR_CAP: psnr_cap <= cfg_wdata[14:0];
        default: ;
      endcase
    end
  end

  // Sequencer for accumulation and the final metrics.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      iter_start <= 1'b0;
      log_start <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      iter_start <= 1'b0;
      log_start <= 1'b0;

      // Output register: loaded with a finished image, emptied when taken.
      if (out_load) begin
        out_valid <= 1'b1;
        mse_o <= mse_r;
        psnr_o <= psnr_r;
        cos_o <= cos_r;
        max_o <= ism_pkg::to_q16(64'(acc.peak));
        mean_o <= mean_r;
        bad_a_o <= ism_pkg::CNT_OUT_W'(acc.bad_a);
        bad_b_o <= ism_pkg::CNT_OUT_W'(acc.bad_b);
        total_o <= ism_pkg::CNT_OUT_W'(acc.pairs);
        pass_o <= pass_r;
      end else if (results.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_IDLE: begin
          if (accept) begin
            last_r <= samples.last_sample;
            state <= S_MAC;
          end
        end
        S_MAC: begin
          if (!mac_busy) begin
            if (!last_r) begin
              state <= S_IDLE;
            end else if (acc.pairs == '0) begin
              mse_r <= '0;
              mean_r <= '0;
              iter_start <= 1'b1;
              iter_cmd <= ism_pkg::mk_sqrt(acc.norm_a);
              state <= S_SQRT_A;
            end else begin
              iter_start <= 1'b1;
              iter_cmd <= ism_pkg::mk_div(64'd0, acc.sum_sq, 64'(acc.pairs),
                                          ism_pkg::STEP_W'(64));
              state <= S_DIV_SQ;
            end
          end
        end
        S_DIV_SQ: begin
          if (iter_done) begin
            mse_r <= ism_pkg::scale_mse(iter_result);
            iter_start <= 1'b1;
            iter_cmd <= ism_pkg::mk_div(64'd0, {acc.sum_abs, 16'd0}, 64'(acc.pairs),
                                        ism_pkg::STEP_W'(48));
            state <= S_DIV_ABS;
          end
        end
        S_DIV_ABS: begin
          if (iter_done) begin
            mean_r <= ism_pkg::to_q16(iter_result);
            iter_start <= 1'b1;
            iter_cmd <= ism_pkg::mk_sqrt(acc.norm_a);
            state <= S_SQRT_A;
          end
        end
        S_SQRT_A: begin
          if (iter_done) begin
            root_a <= iter_result[31:0];
            iter_start <= 1'b1;
            iter_cmd <= ism_pkg::mk_sqrt(acc.norm_b);
            state <= S_SQRT_B;
          end
        end
        S_SQRT_B: begin
          if (iter_done) begin
            root_b <= iter_result[31:0];
            state <= S_DEN;
          end
        end
        S_DEN: begin
          den_r <= root_a * root_b;
          cneg <= acc.dot[63];
          cmag <= acc.dot[63] ? (~acc.dot + 64'd1) : acc.dot;
          state <= S_COS_CHK;
        end
        S_COS_CHK: begin
          // A zero denominator gives zero; a quotient of one or more clamps to one; otherwise 30 fraction bits.
          if (den_r == 64'd0) begin
            cos_r <= '0;
            state <= S_LOG_GO;
          end else if (cmag >= den_r) begin
            cos_r <= cneg ? -32'(ism_pkg::COS_ONE) : 32'(ism_pkg::COS_ONE);
            state <= S_LOG_GO;
          end else begin
            iter_start <= 1'b1;
            iter_cmd <= ism_pkg::mk_div(cmag, 64'd0, den_r, ism_pkg::STEP_W'(30));
            state <= S_COS;
          end
        end
        S_COS: begin
          if (iter_done) begin
            cos_r <= cneg ? -(32'(iter_result[29:0])) : 32'(iter_result[29:0]);
            state <= S_LOG_GO;
          end
        end
        S_LOG_GO: begin
          if ((acc.pairs == '0) || (acc.sum_sq == '0)) begin
            psnr_r <= $signed({1'b0, psnr_cap});
            state <= S_PASS;
          end else begin
            log_start <= 1'b1;
            log_x <= acc.sum_sq;
            state <= S_LOG_S;
          end
        end
        S_LOG_S: begin
          if (log_done) begin
            log_s <= log_result;
            log_start <= 1'b1;
            log_x <= 64'(acc.pairs);
            state <= S_LOG_N;
          end
        end
        S_LOG_N: begin
          if (log_done) begin
            state <= S_PSNR;
          end
        end
        S_PSNR: begin
          psnr_r <= psnr_clamped;
          state <= S_PASS;
        end
        S_PASS: begin
          pass_r <= (acc.bad_a == '0) && (acc.bad_b == '0) &&
                    (cos_r > $signed({1'b0, cos_th})) &&
                    (psnr_r > $signed({1'b0, psnr_th}));
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_load) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result word.
  assign results.valid = out_valid;
  assign results.mean_sq_error = mse_o;
  assign results.psnr_db = psnr_o;
  assign results.cosine = cos_o;
  assign results.max_abs_diff = max_o;
  assign results.mean_abs_diff = mean_o;
  assign results.bad_count_a = bad_a_o;
  assign results.bad_count_b = bad_b_o;
  assign results.sample_total = total_o;
  assign results.pass_flag = pass_o;

  a_hold_while_waiting: assert property (@(posedge clk) disable iff (rst)
    (results.valid && !results.ready) |=>
      (results.valid && $stable(results.mean_sq_error) && $stable(results.cosine) &&
       $stable(results.sample_total)))
    else $error("result word changed while waiting");

  a_clear_after_result: assert property (@(posedge clk) disable iff (rst)
    out_load |=> (acc.pairs == '0 && acc.sum_sq == '0))
    else $error("accumulators not cleared after result");

  a_cos_range: assert property (@(posedge clk) disable iff (rst)
    results.valid |-> (results.cosine <= 32'sd1073741824 &&
                       results.cosine >= -32'sd1073741824))
    else $error("cosine out of range");

  a_pass_needs_clean: assert property (@(posedge clk) disable iff (rst)
    (results.valid && results.pass_flag) |->
      (results.bad_count_a == '0 && results.bad_count_b == '0))
    else $error("pass with bad samples");

endmodule
